// ===== rtl/lseg_pkg.sv =====
package lseg_pkg;

    localparam int DEF_MAX_PIXELS = 512;
    localparam int MIN_STRIP      = 8;

    localparam int IDX_W      = 9;
    localparam int MODE_W     = 3;
    localparam int STRIP_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int IN_TDATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HUE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SATURATION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOLID_LEVEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAINBOW_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LENGTH    = 3'd5;

    localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BOUNCE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FADE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SOLID   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PULSE   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_HOLD    = 3'd7;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [MODE_W-1:0]  RST_EFFECT_MODE     = 3'd0;
    localparam logic [7:0]         RST_BASE_HUE        = 8'd149;
    localparam logic [7:0]         RST_BASE_SATURATION = 8'd255;
    localparam logic [7:0]         RST_SOLID_LEVEL     = 8'd255;
    localparam logic [7:0]         RST_RAINBOW_STEP    = 8'd1;
    localparam logic [STRIP_W-1:0] RST_STRIP_LENGTH    = 10'd300;

    localparam logic [7:0] FULL_LEVEL = 8'd255;
    localparam logic [7:0] TRAIL_1    = 8'd150;
    localparam logic [7:0] TRAIL_2    = 8'd80;
    localparam logic [7:0] TRAIL_3    = 8'd20;
    localparam logic [8:0] PULSE_TOP  = 9'd255;
    localparam logic [8:0] PULSE_STEP = 9'd2;
    localparam logic [8:0] PULSE_MAX  = 9'd256;

    typedef struct packed {
        logic [7:0] val;
        logic [7:0] sat;
        logic [7:0] hue;
    } t_hsv;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_PREP,
        ST_RENDER
    } t_state;

endpackage

// ===== rtl/led_strip_effect_generator.sv =====
// Tick word: setup, neighbor prep, then one frame store write per pixel; a hold
// mode with no mode change returns to idle straight after setup.
// Read word: the frame store is read at the accepting edge, then the result
// goes to the output register once it is free; no word is taken while it waits.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all MAX_PIXELS
// frame store entries, during which no input word is accepted.
module led_strip_effect_generator #(
    parameter int MAX_PIXELS = lseg_pkg::DEF_MAX_PIXELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [lseg_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,  // [8:0] pixel_index
    input  logic                            i_s_axis_tuser,  // [0] cmd
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [7:0] pixel_hue, [15:8] pixel_saturation, [23:16] pixel_value
    output logic [23:0]                     o_m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lseg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lseg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lseg_pkg::*;

    localparam int AW = $clog2(MAX_PIXELS);
    localparam int XW = ((AW > IDX_W) ? AW : IDX_W) + 1;

    logic [MODE_W-1:0]  r_mode;
    logic [7:0]         r_base_hue;
    logic [7:0]         r_base_sat;
    logic [7:0]         r_solid;
    logic [7:0]         r_step;
    logic [STRIP_W-1:0] r_strip_len;

    logic    r_rd_pend;
    logic    r_rd_oob;
    logic    r_out_valid;
    t_hsv    r_out;

    logic          in_acc;
    logic          rd_acc;
    logic          tick_acc;
    logic [XW-1:0] idx_x;
    logic [AW-1:0] rd_addr;
    logic          rd_oob;
    logic          out_load;

    logic          rend_idle;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_hsv          wr_px;
    t_hsv          rd_px;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= RST_EFFECT_MODE;
            r_base_hue  <= RST_BASE_HUE;
            r_base_sat  <= RST_BASE_SATURATION;
            r_solid     <= RST_SOLID_LEVEL;
            r_step      <= RST_RAINBOW_STEP;
            r_strip_len <= RST_STRIP_LENGTH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_EFFECT_MODE:     r_mode      <= i_cfg_data[MODE_W-1:0];
                CFG_BASE_HUE:        r_base_hue  <= i_cfg_data[7:0];
                CFG_BASE_SATURATION: r_base_sat  <= i_cfg_data[7:0];
                CFG_SOLID_LEVEL:     r_solid     <= i_cfg_data[7:0];
                CFG_RAINBOW_STEP:    r_step      <= i_cfg_data[7:0];
                CFG_STRIP_LENGTH:    r_strip_len <= i_cfg_data[STRIP_W-1:0];
                default:             r_mode      <= r_mode;
            endcase
        end
    end

    assign o_s_axis_tready = rend_idle && !r_rd_pend;
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign rd_acc   = in_acc && (i_s_axis_tuser == CMD_READ);
    assign tick_acc = in_acc && (i_s_axis_tuser == CMD_TICK);

    assign idx_x   = XW'(i_s_axis_tdata[IDX_W-1:0]);
    assign rd_addr = idx_x[AW-1:0];
    assign rd_oob  = (idx_x >= XW'(MAX_PIXELS));

    assign out_load = r_rd_pend && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rd_acc) begin
                r_rd_pend <= 1'b1;
            end else if (out_load) begin
                r_rd_pend <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_acc) begin
            r_rd_oob <= rd_oob;
        end
        if (out_load) begin
            r_out <= r_rd_oob ? t_hsv'('0) : rd_px;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    lseg_renderer #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_renderer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (tick_acc),
        .i_mode         (r_mode),
        .i_base_hue     (r_base_hue),
        .i_base_sat     (r_base_sat),
        .i_solid_level  (r_solid),
        .i_rainbow_step (r_step),
        .i_strip_length (r_strip_len),
        .o_idle         (rend_idle),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_px        (wr_px)
    );

    lseg_frame_store #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_px),
        .i_re    (rd_acc),
        .i_raddr (rd_addr),
        .o_rdata (rd_px)
    );

    a_read_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_acc |=> r_rd_pend)
        else $error("accepted read not pending");

    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_rd_pend))
        else $error("output word without a read");

    a_read_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (rend_idle && !wr_en))
        else $error("frame store written while a read is pending");

endmodule

// ===== rtl/lseg_frame_store.sv =====
module lseg_frame_store #(
    parameter int MAX_PIXELS = lseg_pkg::DEF_MAX_PIXELS
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(MAX_PIXELS)-1:0] i_waddr,
    input  lseg_pkg::t_hsv                i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(MAX_PIXELS)-1:0] i_raddr,
    output lseg_pkg::t_hsv                o_rdata
);
    import lseg_pkg::*;

    t_hsv mem [MAX_PIXELS];
    t_hsv r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lseg_renderer.sv =====
module lseg_renderer #(
    parameter int MAX_PIXELS = lseg_pkg::DEF_MAX_PIXELS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lseg_pkg::MODE_W-1:0]   i_mode,
    input  logic [7:0]                    i_base_hue,
    input  logic [7:0]                    i_base_sat,
    input  logic [7:0]                    i_solid_level,
    input  logic [7:0]                    i_rainbow_step,
    input  logic [lseg_pkg::STRIP_W-1:0]  i_strip_length,
    output logic                          o_idle,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_PIXELS)-1:0] o_wr_addr,
    output lseg_pkg::t_hsv                o_wr_px
);
    import lseg_pkg::*;

    localparam int AW = $clog2(MAX_PIXELS);
    localparam int NW = $clog2(MAX_PIXELS + 1);
    localparam int LW = (NW > STRIP_W) ? NW : STRIP_W;
    localparam logic [AW-1:0] MEM_LAST = AW'(MAX_PIXELS - 1);

    t_state r_state, n_state;

    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_dot;
    logic          r_down;
    logic [8:0]    r_lvl;
    logic [7:0]    r_ofs;
    logic [MODE_W-1:0] r_prev;
    logic          r_blank;
    logic [7:0]    r_hue;
    logic [AW-1:0] r_l1, r_l2, r_l3, r_r1, r_r2, r_r3;

    logic [NW-1:0] n_used;
    logic [AW-1:0] n_last;
    logic [LW-1:0] sl_x;
    logic          blank;
    logic          hold;
    logic [AW-1:0] mv_dot;
    logic          mv_down;
    logic [8:0]    pl_lvl;
    logic          pl_down;
    logic [AW-1:0] nb_l1, nb_l2, nb_l3, nb_r1, nb_r2, nb_r3;
    logic [7:0]    dot_v;

    function automatic logic [AW-1:0] step_cw(input logic [AW-1:0] i, input logic [NW-1:0] n);
        if ((NW + 1)'(i) + (NW + 1)'(1) < (NW + 1)'(n)) begin
            return i + AW'(1);
        end else begin
            return '0;
        end
    endfunction

    function automatic logic [AW-1:0] step_ccw(input logic [AW-1:0] i, input logic [NW-1:0] n);
        if (i != '0) begin
            return i - AW'(1);
        end else begin
            return AW'(n - NW'(1));
        end
    endfunction

    always_comb begin
        sl_x = LW'(i_strip_length);
        if (sl_x < LW'(MIN_STRIP)) begin
            n_used = NW'(MIN_STRIP);
        end else if (sl_x > LW'(MAX_PIXELS)) begin
            n_used = NW'(MAX_PIXELS);
        end else begin
            n_used = NW'(sl_x);
        end
        n_last = AW'(n_used - NW'(1));
        blank  = (i_mode != r_prev);
        hold   = (i_mode > MODE_PULSE);
    end

    // dot motion
    always_comb begin
        mv_dot  = r_dot;
        mv_down = r_down;
        if (!mv_down) begin
            if ((NW + 1)'(mv_dot) + (NW + 1)'(1) >= (NW + 1)'(n_used)) begin
                mv_down = 1'b1;
                mv_dot  = n_last;
            end else begin
                mv_dot = mv_dot + AW'(1);
            end
        end
        if (mv_down) begin
            if (mv_dot == '0) begin
                mv_down = 1'b0;
            end else begin
                mv_dot = mv_dot - AW'(1);
                if (mv_dot == '0) begin
                    mv_down = 1'b0;
                end
            end
        end
    end

    // pulse level
    always_comb begin
        pl_lvl  = r_lvl;
        pl_down = r_down;
        if (!pl_down) begin
            pl_lvl = pl_lvl + PULSE_STEP;
            if (pl_lvl >= PULSE_TOP) begin
                pl_down = 1'b1;
            end
        end
        if (pl_down) begin
            pl_lvl = (pl_lvl >= PULSE_STEP) ? pl_lvl - PULSE_STEP : 9'd0;
            if (pl_lvl <= 9'd1) begin
                pl_down = 1'b0;
            end
        end
    end

    always_comb begin
        nb_l1 = step_cw(r_dot, n_used);
        nb_l2 = step_cw(nb_l1, n_used);
        nb_l3 = step_cw(nb_l2, n_used);
        nb_r1 = step_ccw(r_dot, n_used);
        nb_r2 = step_ccw(nb_r1, n_used);
        nb_r3 = step_ccw(nb_r2, n_used);
    end

    always_comb begin
        if (r_idx == r_dot) begin
            dot_v = FULL_LEVEL;
        end else if (i_mode != MODE_FADE) begin
            dot_v = 8'd0;
        end else if (r_idx == r_l1) begin
            dot_v = TRAIL_1;
        end else if (r_idx == r_l2) begin
            dot_v = TRAIL_2;
        end else if (r_idx == r_l3) begin
            dot_v = TRAIL_3;
        end else if (r_idx == r_r1) begin
            dot_v = TRAIL_1;
        end else if (r_idx == r_r2) begin
            dot_v = TRAIL_2;
        end else if (r_idx == r_r3) begin
            dot_v = TRAIL_3;
        end else begin
            dot_v = 8'd0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_idx == MEM_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                n_state = (!blank && hold) ? ST_IDLE : ST_PREP;
            end
            ST_PREP: begin
                n_state = ST_RENDER;
            end
            ST_RENDER: begin
                if (r_idx == n_last) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_idle    = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx;
        o_wr_px   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_wr_en = 1'b1;
            end
            ST_IDLE: begin
                o_idle = 1'b1;
            end
            ST_RENDER: begin
                o_wr_en = 1'b1;
                if (!r_blank) begin
                    case (i_mode)
                        MODE_RAINBOW: o_wr_px = '{val: FULL_LEVEL, sat: FULL_LEVEL, hue: r_hue};
                        MODE_BOUNCE, MODE_FADE: begin
                            if (dot_v != 8'd0) begin
                                o_wr_px = '{val: dot_v, sat: i_base_sat, hue: i_base_hue};
                            end
                        end
                        MODE_SOLID: o_wr_px = '{val: i_solid_level, sat: i_base_sat,
                                                hue: i_base_hue};
                        MODE_PULSE: o_wr_px = '{val: r_lvl[7:0], sat: i_base_sat,
                                                hue: i_base_hue};
                        default: o_wr_px = '0;
                    endcase
                end
            end
            default: begin
                o_idle = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_dot   <= '0;
            r_down  <= 1'b0;
            r_lvl   <= 9'd0;
            r_ofs   <= 8'd0;
            r_prev  <= RST_EFFECT_MODE;
            r_blank <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_CLEAR: begin
                    r_idx <= (r_idx == MEM_LAST) ? '0 : r_idx + AW'(1);
                end
                ST_SETUP: begin
                    r_idx   <= '0;
                    r_blank <= blank;
                    if (i_mode == MODE_RAINBOW) begin
                        r_ofs <= r_ofs + 8'd1;
                    end
                    if (blank) begin
                        r_dot  <= '0;
                        r_down <= 1'b0;
                        r_lvl  <= 9'd0;
                        r_prev <= i_mode;
                    end else begin
                        case (i_mode)
                            MODE_BOUNCE, MODE_FADE: begin
                                r_dot  <= mv_dot;
                                r_down <= mv_down;
                            end
                            MODE_PULSE: begin
                                r_lvl  <= pl_lvl;
                                r_down <= pl_down;
                            end
                            default: begin
                                r_dot <= r_dot;
                            end
                        endcase
                    end
                end
                ST_RENDER: begin
                    r_idx <= r_idx + AW'(1);
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SETUP) begin
            r_hue <= r_ofs;
        end else if (r_state == ST_RENDER) begin
            r_hue <= r_hue + i_rainbow_step;
        end
        if (r_state == ST_PREP) begin
            r_l1 <= nb_l1;
            r_l2 <= nb_l2;
            r_l3 <= nb_l3;
            r_r1 <= nb_r1;
            r_r2 <= nb_r2;
            r_r3 <= nb_r3;
        end
    end

    a_render_in_strip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RENDER |-> NW'(r_idx) < n_used)
        else $error("render index beyond strip");

    a_render_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RENDER && r_idx == n_last) |=> r_state == ST_IDLE)
        else $error("render pass did not end at last pixel");

    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_lvl[0] && r_lvl <= PULSE_MAX)
        else $error("pulse level out of range");

endmodule

// ===== verif/pixel_check_pkg.sv =====
package pixel_check_pkg;

    import lseg_pkg::*;

    class pixel_scoreboard;

        t_hsv               frame[DEF_MAX_PIXELS];
        logic [IDX_W-1:0]   dot_pos;
        logic               going_down;
        logic [8:0]         pulse;
        logic [7:0]         hue_offset;
        logic [MODE_W-1:0]  last_mode;

        logic [MODE_W-1:0]  mode;
        logic [7:0]         hue;
        logic [7:0]         sat;
        logic [7:0]         solid;
        logic [7:0]         step;
        logic [STRIP_W-1:0] strip;

        t_hsv               pixel_q[$];
        int                 errors;

        function new();
            foreach (frame[i]) frame[i] = '0;
            dot_pos    = '0;
            going_down = 1'b0;
            pulse      = '0;
            hue_offset = '0;
            last_mode  = '0;
            mode       = RST_EFFECT_MODE;
            hue        = RST_BASE_HUE;
            sat        = RST_BASE_SATURATION;
            solid      = RST_SOLID_LEVEL;
            step       = RST_RAINBOW_STEP;
            strip      = RST_STRIP_LENGTH;
            errors     = 0;
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("%t  ERROR: %s", $realtime, msg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_EFFECT_MODE:     mode  = data[MODE_W-1:0];
                CFG_BASE_HUE:        hue   = data[7:0];
                CFG_BASE_SATURATION: sat   = data[7:0];
                CFG_SOLID_LEVEL:     solid = data[7:0];
                CFG_RAINBOW_STEP:    step  = data[7:0];
                CFG_STRIP_LENGTH:    strip = data[STRIP_W-1:0];
                default: ;
            endcase
        endfunction

        function t_hsv hsv(logic [7:0] h, logic [7:0] s, logic [7:0] v);
            t_hsv px;
            px.hue = h;
            px.sat = s;
            px.val = v;
            return px;
        endfunction

        function void fill(int n, t_hsv px);
            for (int i = 0; i < n; i++) frame[i] = px;
        endfunction

        function void move_dot(int n);
            if (!going_down) begin
                if (dot_pos + 1 >= n) begin
                    going_down = 1'b1;
                    dot_pos    = IDX_W'(n - 1);
                end else begin
                    dot_pos = dot_pos + IDX_W'(1);
                end
            end
            if (going_down) begin
                if (dot_pos == 0) begin
                    going_down = 1'b0;
                end else begin
                    dot_pos = dot_pos - IDX_W'(1);
                    if (dot_pos == 0) going_down = 1'b0;
                end
            end
        endfunction

        function void render_dot(int n, bit trail);
            int         p;
            int         l1, l2, l3, r1, r2, r3;
            logic [7:0] v;
            p  = int'(dot_pos);
            l1 = (p + 1 < n) ? p + 1 : 0;
            l2 = (l1 + 1 < n) ? l1 + 1 : 0;
            l3 = (l2 + 1 < n) ? l2 + 1 : 0;
            r1 = (p > 0) ? p - 1 : n - 1;
            r2 = (r1 > 0) ? r1 - 1 : n - 1;
            r3 = (r2 > 0) ? r2 - 1 : n - 1;
            for (int i = 0; i < n; i++) begin
                if (i == p)       v = FULL_LEVEL;
                else if (!trail)  v = 8'd0;
                else if (i == l1) v = TRAIL_1;
                else if (i == l2) v = TRAIL_2;
                else if (i == l3) v = TRAIL_3;
                else if (i == r1) v = TRAIL_1;
                else if (i == r2) v = TRAIL_2;
                else if (i == r3) v = TRAIL_3;
                else              v = 8'd0;
                frame[i] = (v == 8'd0) ? t_hsv'('0) : hsv(hue, sat, v);
            end
        endfunction

        function void render_frame();
            int n;
            int hue_sum;
            n = (strip < MIN_STRIP) ? MIN_STRIP :
                (strip > DEF_MAX_PIXELS) ? DEF_MAX_PIXELS : int'(strip);
            case (mode)
                MODE_RAINBOW: begin
                    for (int i = 0; i < n; i++) begin
                        hue_sum  = hue_offset + i * step;
                        frame[i] = hsv(hue_sum[7:0], FULL_LEVEL, FULL_LEVEL);
                    end
                    hue_offset = hue_offset + 8'd1;
                end
                MODE_BOUNCE: begin
                    move_dot(n);
                    render_dot(n, 1'b0);
                end
                MODE_FADE: begin
                    move_dot(n);
                    render_dot(n, 1'b1);
                end
                MODE_SOLID: fill(n, hsv(hue, sat, solid));
                MODE_PULSE: begin
                    if (!going_down) begin
                        pulse = pulse + PULSE_STEP;
                        if (pulse >= PULSE_TOP) going_down = 1'b1;
                    end
                    if (going_down) begin
                        pulse = (pulse >= PULSE_STEP) ? pulse - PULSE_STEP : 9'd0;
                        if (pulse <= 9'd1) going_down = 1'b0;
                    end
                    fill(n, hsv(hue, sat, pulse[7:0]));
                end
                default: ;
            endcase
            if (mode != last_mode) begin
                fill(n, '0);
                pulse      = '0;
                dot_pos    = '0;
                going_down = 1'b0;
                last_mode  = mode;
            end
        endfunction

        function void note_word(logic cmd, logic [IDX_W-1:0] idx);
            if (cmd == CMD_TICK) render_frame();
            else pixel_q.push_back(frame[idx]);
        endfunction

        function void check_word(logic [23:0] data);
            t_hsv got;
            t_hsv exp_px;
            got = data;
            if (pixel_q.size() == 0) begin
                flag($sformatf("unexpected pixel h=%0d s=%0d v=%0d",
                               got.hue, got.sat, got.val));
                return;
            end
            exp_px = pixel_q.pop_front();
            if (got.hue !== exp_px.hue || got.sat !== exp_px.sat ||
                got.val !== exp_px.val)
                flag($sformatf("pixel exp h=%0d s=%0d v=%0d got h=%0d s=%0d v=%0d",
                               exp_px.hue, exp_px.sat, exp_px.val,
                               got.hue, got.sat, got.val));
        endfunction

    endclass

endpackage

// ===== verif/tb.sv =====
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lseg_pkg::*;
    import pixel_check_pkg::*;

    localparam int DRAIN_CYCLES = DEF_MAX_PIXELS + 88;
    localparam int QUIET_LIMIT  = 4000;
    localparam int NUM_PHASES   = 15;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_TDATA_W-1:0] i_s_axis_tdata  = '0;  // [8:0] pixel_index
    logic                  i_s_axis_tuser  = 1'b0;  // [0] cmd
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [23:0]           o_m_axis_tdata;  // [7:0] hue, [15:8] sat, [23:16] value
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    int tx_idle_pct = 9;
    int rx_idle_pct = 67;

    logic [STRIP_W-1:0] strip_edges[8] = '{10'd0, 10'd7, 10'd8, 10'd9,
                                           10'd511, 10'd512, 10'd513, 10'd1023};

    pixel_scoreboard sb = new();

    led_strip_effect_generator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) sb.check_word(o_m_axis_tdata);
    end

    initial begin : watchdog
        int quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (i_cfg_valid && o_cfg_ready) ||
                (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("led_strip_effect_generator test failed");
        $finish;
    end

    task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {{(IN_TDATA_W-IDX_W){1'b0}}, idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_word(cmd, idx);
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data[CFG_DATA_W-1:0]);
    endtask

    task automatic set_regs(input int mode, input int hue, input int sat,
                            input int level, input int step, input int strip);
        settle();
        write_reg(CFG_EFFECT_MODE, mode);
        write_reg(CFG_BASE_HUE, hue);
        write_reg(CFG_BASE_SATURATION, sat);
        write_reg(CFG_SOLID_LEVEL, level);
        write_reg(CFG_RAINBOW_STEP, step);
        write_reg(CFG_STRIP_LENGTH, strip);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 20) return 255;
        return $urandom_range(255);
    endfunction

    initial begin
        int mode;
        int strip;
        int used;
        int span;
        int r;
        int n_words;
        int tick_pct;
        logic [IDX_W-1:0] idx;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cleared store, then rainbow with reset settings
        send_word(CMD_READ, 9'd0);
        send_word(CMD_READ, 9'd511);
        send_word(CMD_TICK, 9'd0);
        send_word(CMD_READ, 9'd0);
        send_word(CMD_READ, 9'd299);
        send_word(CMD_READ, 9'd300);
        send_word(CMD_TICK, 9'd0);
        send_word(CMD_READ, 9'd1);

        // bounce on a strip below the minimum
        set_regs(int'(MODE_BOUNCE), 0, 255, 0, 255, 0);
        repeat (4) send_word(CMD_TICK, 9'd0);
        send_word(CMD_READ, 9'd0);
        send_word(CMD_READ, 9'd3);

        // fade on an oversize strip, trail wraps past pixel zero
        set_regs(int'(MODE_FADE), 255, 0, 255, 0, 1023);
        repeat (3) send_word(CMD_TICK, 9'd0);
        send_word(CMD_READ, 9'd511);
        send_word(CMD_READ, 9'd510);
        send_word(CMD_READ, 9'd3);

        // hold mode still blanks on the change
        set_regs(int'(MODE_HOLD), 149, 255, 255, 1, 8);
        send_word(CMD_TICK, 9'd0);
        send_word(CMD_READ, 9'd0);

        mode = int'(MODE_HOLD);
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 5) begin
                tx_idle_pct = 67;
                rx_idle_pct = 9;
            end else if (p == 10) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p < 8) mode = p;
            else if ($urandom_range(1) == 0) mode = $urandom_range(int'(MODE_HOLD));

            r = $urandom_range(99);
            if (p == int'(MODE_PULSE)) strip = $urandom_range(16, 8);
            else if (r < 65) strip = $urandom_range(40, 8);
            else if (r < 85) strip = $urandom_range(1023);
            else strip = int'(strip_edges[$urandom_range(7)]);
            set_regs(mode, pick_byte(), pick_byte(), pick_byte(), pick_byte(), strip);

            used = (strip < MIN_STRIP) ? MIN_STRIP :
                   (strip > DEF_MAX_PIXELS) ? DEF_MAX_PIXELS : strip;
            span = (used + 2 > 511) ? 511 : used + 2;
            if (p == int'(MODE_PULSE)) begin
                n_words  = 380;
                tick_pct = 90;
            end else begin
                n_words  = 80;
                tick_pct = (mode == MODE_BOUNCE || mode == MODE_FADE ||
                            mode == MODE_PULSE) ? 60 : 35;
            end

            for (int k = 0; k < n_words; k++) begin
                if ($urandom_range(99) < tick_pct) begin
                    send_word(CMD_TICK, IDX_W'($urandom_range(511)));
                end else begin
                    if ($urandom_range(99) < 75) idx = IDX_W'($urandom_range(span));
                    else idx = IDX_W'($urandom_range(511));
                    send_word(CMD_READ, idx);
                end
            end
        end

        settle();
        if (sb.errors == 0)
            $display("led_strip_effect_generator test passed");
        else
            $display("led_strip_effect_generator test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lseg_pkg.sv
rtl/lseg_frame_store.sv
rtl/lseg_renderer.sv
rtl/led_strip_effect_generator.sv
verif/pixel_check_pkg.sv
verif/tb.sv
